[rtl/core/file_transfer_packet_checker_assert.svh]
// ----------------------------------------------------------------------------
// file_transfer_packet_checker_assert
// Assertion macros used by the packet checker top level.
// ----------------------------------------------------------------------------
`ifndef FILE_TRANSFER_PACKET_CHECKER_ASSERT_SVH
`define FILE_TRANSFER_PACKET_CHECKER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FTPC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ftpc assertion failed");

// next-cycle implication, disabled in reset
`define FTPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ftpc assertion failed");

`endif

[rtl/core/ftpc_pkg.sv]
// ----------------------------------------------------------------------------
// ftpc_pkg
// Types and protocol constants for the file transfer packet checker.
// ----------------------------------------------------------------------------
package ftpc_pkg;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_DATA = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_DATA  = 2'd1,
    K_START = 2'd2,
    K_END   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OK   = 3'd0,
    ERR_CTRL = 3'd1,
    ERR_SIZE = 3'd2,
    ERR_NAME = 3'd3,
    ERR_SEQ  = 3'd4,
    ERR_LEN  = 3'd5
  } err_t;

  // packet type bytes
  localparam logic [7:0] CTRL_DATA  = 8'h01;
  localparam logic [7:0] CTRL_START = 8'h02;
  localparam logic [7:0] CTRL_END   = 8'h03;

  // parameter fields of start and end packets
  localparam logic [7:0] PARAM_SIZE     = 8'h00;
  localparam logic [7:0] PARAM_NAME     = 8'h01;
  localparam logic [7:0] SIZE_PARAM_LEN = 8'd2;

  localparam logic [7:0] SEQ_RESET = 8'd1;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        packet_end;
    err_t        status;
    logic [15:0] file_size;
    logic        transfer_done;
  } result_t;

endpackage

[rtl/core/file_transfer_packet_checker.sv]
// a byte accepted into the input register moves into the result register when
// that slot frees up, and its result is presented from there
// throughput: one byte per cycle; a stalled result holds the input register,
// which then stalls the input side
// reset: synchronous rst returns the session to waiting for a start packet,
// clears the error and size, and empties both registers
// ----------------------------------------------------------------------------
// file_transfer_packet_checker
// Start / data / end packet session checker with payload pass-through.
// ----------------------------------------------------------------------------
`include "file_transfer_packet_checker_assert.svh"

module file_transfer_packet_checker #(
  parameter int MAX_PACKET_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        payload_valid,
  output logic [7:0]  payload_byte,
  output logic        packet_end,
  output logic [2:0]  status,
  output logic [15:0] file_size,
  output logic        transfer_done
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_last;
  logic              advance;
  ftpc_pkg::result_t res;
  ftpc_pkg::result_t out_res;

  // move the held byte into the result register when that slot frees up
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  ftpc_session #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_session (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_res   <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      out_res   <= res;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign payload_valid = out_res.payload_valid;
  assign payload_byte  = out_res.payload_byte;
  assign packet_end    = out_res.packet_end;
  assign status        = 3'(out_res.status);
  assign file_size     = out_res.file_size;
  assign transfer_done = out_res.transfer_done;

  // errors are sticky until reset
  `FTPC_ASSERT_NEXT(a_err_sticky, clk, rst, status != 3'(ftpc_pkg::ERR_OK), status == $past(status))
  // once done, the session stays done
  `FTPC_ASSERT_NEXT(a_done_sticky, clk, rst, transfer_done, transfer_done)
  // no file data is passed after the end packet
  `FTPC_ASSERT_NOW(a_no_payload_done, clk, rst, out_valid && payload_valid, !transfer_done)
  // an empty result slot never holds back the input side
  `FTPC_ASSERT_NOW(a_no_false_stall, clk, rst, !out_valid, !in_stall)

endmodule

[rtl/core/ftpc_session.sv]
// ----------------------------------------------------------------------------
// ftpc_session
// Session state and per-byte checks; gives the result for the byte presented.
// ----------------------------------------------------------------------------
module ftpc_session #(
  parameter int MAX_PACKET_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output ftpc_pkg::result_t  res
);

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CW = (PW > 16) ? PW : 16;

  ftpc_pkg::phase_t phase, phase_next;
  ftpc_pkg::kind_t  kind, kind_next;
  ftpc_pkg::err_t   error_code, error_next;
  logic [PW-1:0]    pos, pos_next;
  logic [7:0]       seq, seq_next;
  logic [15:0]      dlen, dlen_next;
  logic [15:0]      size_reg, size_next;
  logic             pv;
  logic             is_ctrl;

  always_comb begin
    phase_next = phase;
    kind_next  = kind;
    error_next = error_code;
    pos_next   = pos;
    seq_next   = seq;
    dlen_next  = dlen;
    size_next  = size_reg;
    pv         = 1'b0;
    is_ctrl    = (kind == ftpc_pkg::K_START) || (kind == ftpc_pkg::K_END);

    if (error_code == ftpc_pkg::ERR_OK && phase != ftpc_pkg::PH_DONE) begin
      if (pos >= PW'(MAX_PACKET_BYTES)) begin
        error_next = ftpc_pkg::ERR_LEN;
      end else begin
        if (pos == '0) begin
          if (phase == ftpc_pkg::PH_WAIT) begin
            if (data_byte == ftpc_pkg::CTRL_START) kind_next = ftpc_pkg::K_START;
            else error_next = ftpc_pkg::ERR_CTRL;
          end else if (data_byte == ftpc_pkg::CTRL_DATA) begin
            kind_next = ftpc_pkg::K_DATA;
          end else if (data_byte == ftpc_pkg::CTRL_END) begin
            kind_next = ftpc_pkg::K_END;
          end else begin
            kind_next = ftpc_pkg::K_NONE;
          end
        end else if (is_ctrl) begin
          if (pos == PW'(1) && data_byte != ftpc_pkg::PARAM_SIZE)
            error_next = ftpc_pkg::ERR_SIZE;
          else if (pos == PW'(2) && data_byte != ftpc_pkg::SIZE_PARAM_LEN)
            error_next = ftpc_pkg::ERR_SIZE;
          else if (pos == PW'(3))
            dlen_next = {data_byte, 8'h00};
          else if (pos == PW'(4))
            dlen_next = {dlen[15:8], data_byte};
          else if (pos == PW'(5) && data_byte != ftpc_pkg::PARAM_NAME)
            error_next = ftpc_pkg::ERR_NAME;
        end else if (kind == ftpc_pkg::K_DATA) begin
          if (pos == PW'(1) && data_byte != seq)
            error_next = ftpc_pkg::ERR_SEQ;
          else if (pos == PW'(2))
            dlen_next = {data_byte, 8'h00};
          else if (pos == PW'(3))
            dlen_next = {dlen[15:8], data_byte};
          // payload starts after type, sequence and two length bytes
          pv = (pos >= PW'(4));
        end

        // end-of-packet checks, only if this byte raised nothing
        if (error_next == ftpc_pkg::ERR_OK && last_byte) begin
          if (is_ctrl) begin
            if (pos < PW'(4)) begin
              error_next = ftpc_pkg::ERR_SIZE;
            end else if (pos < PW'(5)) begin
              error_next = ftpc_pkg::ERR_NAME;
            end else begin
              size_next  = dlen_next;
              phase_next = (kind == ftpc_pkg::K_END) ? ftpc_pkg::PH_DONE
                                                     : ftpc_pkg::PH_DATA;
            end
          end else if (kind == ftpc_pkg::K_DATA) begin
            if (pos < PW'(1))
              error_next = ftpc_pkg::ERR_SEQ;
            else if (pos < PW'(3))
              error_next = ftpc_pkg::ERR_LEN;
            else if (CW'(dlen_next) != CW'(pos - PW'(3)))
              error_next = ftpc_pkg::ERR_LEN;
            else
              seq_next = seq + 8'd1;
          end
        end

        pos_next = last_byte ? '0 : pos + PW'(1);
        if (last_byte) kind_next = ftpc_pkg::K_NONE;
      end
    end

    res.payload_valid = pv;
    res.payload_byte  = pv ? data_byte : 8'h00;
    res.packet_end    = last_byte;
    res.status        = error_next;
    res.file_size     = size_next;
    res.transfer_done = (phase_next == ftpc_pkg::PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ftpc_pkg::PH_WAIT;
      kind       <= ftpc_pkg::K_NONE;
      error_code <= ftpc_pkg::ERR_OK;
      pos        <= '0;
      seq        <= ftpc_pkg::SEQ_RESET;
      dlen       <= 16'h0000;
      size_reg   <= 16'h0000;
    end else if (step) begin
      phase      <= phase_next;
      kind       <= kind_next;
      error_code <= error_next;
      pos        <= pos_next;
      seq        <= seq_next;
      dlen       <= dlen_next;
      size_reg   <= size_next;
    end
  end

endmodule
